// ===== sv/bkst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded key set table package
// Shared widths, types and status codes for the key set table.
// ----------------------------------------------------------------------------
package bkst_pkg;

    localparam int SLOTS       = 64;
    localparam int KEY_SYMBOLS = 10;
    localparam int SYMBOL_BITS = 6;
    localparam int KEY_W       = 60;
    localparam int KEY_BITS    = SYMBOL_BITS * KEY_SYMBOLS;
    localparam int ADDR_W      = $clog2(SLOTS);

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_action;
    typedef logic [3:0]        t_status;

    localparam t_key KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

    localparam t_action ACT_ADD      = 2'd0;
    localparam t_action ACT_REMOVE   = 2'd1;
    localparam t_action ACT_EXCHANGE = 2'd2;
    localparam t_action ACT_LIST     = 2'd3;

    localparam t_status ST_ADDED     = 4'd0;
    localparam t_status ST_DUP       = 4'd1;
    localparam t_status ST_FULL      = 4'd2;
    localparam t_status ST_REMOVED   = 4'd3;
    localparam t_status ST_ABSENT    = 4'd4;
    localparam t_status ST_EXCHANGED = 4'd5;
    localparam t_status ST_LISTED    = 4'd6;
    localparam t_status ST_EMPTY     = 4'd7;
    localparam t_status ST_INVALID   = 4'd8;

endpackage

// ===== sv/bkst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded key set table slot memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bkst_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/bounded_key_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded key set table
// Set of name keys in slots with add, remove, exchange and list commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. An invalid command
// (zero key, or zero new key for an exchange) and a list of an empty table
// answer in the cycle after they are taken. Every other command sweeps all
// slots through the single read port of the slot memory, one slot a cycle. An
// add, remove or exchange answers once, from the finish state after the
// sweep; a list gives its results during the sweep, at most one a cycle.
// Each result is shown for one cycle only, flagged by o_result_valid, and the
// receiver cannot hold it off. Slot occupancy lives in flip-flops cleared by
// reset, so the table is usable straight after reset.
module bounded_key_set_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bkst_pkg::t_action i_action,
    input  bkst_pkg::t_key    i_key,
    input  bkst_pkg::t_key    i_new_key,
    input  logic              i_closes_request,
    output logic              o_result_valid,
    output bkst_pkg::t_status o_status,
    output bkst_pkg::t_key    o_reported_key,
    output logic              o_last,
    output logic              o_request_end
);
    import bkst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam t_addr      LAST_ADDR = t_addr'(SLOTS - 1);

    logic [1:0]       r_state;
    logic [SLOTS-1:0] r_valid;
    t_action          r_action;
    t_key             r_key;
    t_key             r_new_key;
    logic             r_closes;
    t_addr            r_addr;
    logic             r_issue;
    logic             r_rd_pend;
    t_addr            r_rd_idx;
    logic             r_hit_a;
    t_addr            r_idx_a;
    logic             r_hit_b;
    logic             r_free_found;
    t_addr            r_free_idx;

    logic             r_out_valid;
    t_status          r_out_status;
    t_key             r_out_key;
    logic             r_out_last;
    logic             r_out_end;

    t_key             rdata;
    t_key             in_key;
    t_key             in_new_key;
    logic             ent_valid;
    t_key             ent;
    logic             upper_any;
    logic             mem_we;
    t_addr            mem_waddr;
    t_key             mem_wdata;
    logic             accept;

    assign in_key     = i_key & KEY_MASK;
    assign in_new_key = i_new_key & KEY_MASK;
    assign accept     = start && (r_state == S_IDLE);
    assign ent_valid  = r_valid[r_rd_idx];
    assign ent        = ent_valid ? rdata : '0;
    assign upper_any  = |(r_valid & (({SLOTS{1'b1}} << r_rd_idx) << 1));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_free_idx;
        mem_wdata = r_key;
        if (r_state == S_FINISH) begin
            if (r_action == ACT_ADD) begin
                mem_we = r_free_found && !r_hit_a;
            end else if (r_action == ACT_EXCHANGE) begin
                mem_we    = r_hit_a && !r_hit_b;
                mem_waddr = r_idx_a;
                mem_wdata = r_new_key;
            end
        end
    end

    bkst_ram #(
        .DEPTH(SLOTS),
        .WIDTH(KEY_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (r_issue),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_issue     <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action     <= i_action;
                        r_key        <= in_key;
                        r_new_key    <= in_new_key;
                        r_closes     <= i_closes_request;
                        r_addr       <= '0;
                        r_hit_a      <= 1'b0;
                        r_hit_b      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_out_last   <= 1'b1;
                        r_out_end    <= i_closes_request;
                        if (i_action != ACT_LIST && (in_key == '0 ||
                            (i_action == ACT_EXCHANGE && in_new_key == '0))) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_INVALID;
                            r_out_key    <= '0;
                        end else if (i_action == ACT_LIST && r_valid == '0) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_EMPTY;
                            r_out_key    <= '0;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= r_issue;
                    r_rd_idx  <= r_addr;
                    if (r_issue) begin
                        if (r_addr == LAST_ADDR) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_pend) begin
                        if (ent_valid && ent == r_key && !r_hit_a) begin
                            r_hit_a <= 1'b1;
                            r_idx_a <= r_rd_idx;
                        end
                        if (ent_valid && ent == r_new_key) begin
                            r_hit_b <= 1'b1;
                        end
                        if (!ent_valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                        if (r_action == ACT_LIST && ent_valid) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_LISTED;
                            r_out_key    <= ent;
                            r_out_last   <= !upper_any;
                            r_out_end    <= !upper_any && r_closes;
                        end
                        if (r_rd_idx == LAST_ADDR) begin
                            r_rd_pend <= 1'b0;
                            r_state   <= (r_action == ACT_LIST) ? S_IDLE : S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b1;
                    r_out_end   <= r_closes;
                    r_out_key   <= r_key;
                    r_state     <= S_IDLE;
                    case (r_action)
                        ACT_ADD: begin
                            if (!r_free_found) begin
                                r_out_status <= ST_FULL;
                            end else if (r_hit_a) begin
                                r_out_status <= ST_DUP;
                            end else begin
                                r_out_status        <= ST_ADDED;
                                r_valid[r_free_idx] <= 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_hit_a) begin
                                r_out_status     <= ST_REMOVED;
                                r_valid[r_idx_a] <= 1'b0;
                            end else begin
                                r_out_status <= ST_ABSENT;
                            end
                        end
                        ACT_EXCHANGE: begin
                            if (!r_hit_a) begin
                                r_out_status <= ST_ABSENT;
                            end else if (r_hit_b) begin
                                r_out_status <= ST_DUP;
                                r_out_key    <= r_new_key;
                            end else begin
                                r_out_status <= ST_EXCHANGED;
                            end
                        end
                        default: begin
                            r_out_valid <= 1'b0;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_reported_key = r_out_key;
    assign o_last         = r_out_last;
    assign o_request_end  = r_out_end;

endmodule

// ===== sim/bounded_key_set_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded key set table checker
// Watches the command and result channels of the key set table, keeps its own
// copy of the slot contents, predicts the results of every accepted command
// and compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_key_set_table_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  bkst_pkg::t_action i_action,
    input  bkst_pkg::t_key    i_key,
    input  bkst_pkg::t_key    i_new_key,
    input  logic              i_closes_request,
    input  logic              i_result_valid,
    input  bkst_pkg::t_status i_status,
    input  bkst_pkg::t_key    i_reported_key,
    input  logic              i_last,
    input  logic              i_request_end,
    output int                o_fail_count,
    output int                o_pending
);
    import bkst_pkg::*;

    typedef struct packed {
        t_status status;
        t_key    reported_key;
        logic    last;
        logic    request_end;
    } t_answer;

    t_key    table_keys [SLOTS];
    t_answer answer_q [$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int find_slot(input t_key k);
        for (int i = 0; i < SLOTS; i++) begin
            if (table_keys[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (fail_count < 100) begin
            $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
        end
        fail_count++;
    endtask

    task automatic push_answer(input t_status st, input t_key k);
        t_answer a;
        a.status       = st;
        a.reported_key = k & KEY_MASK;
        a.last         = 1'b0;
        a.request_end  = 1'b0;
        answer_q.push_back(a);
    endtask

    task automatic predict_command(input t_action act, input t_key key_in,
                                   input t_key new_in, input logic closes);
        t_key k;
        t_key nk;
        int   free_slot;
        int   old_slot;
        int   new_slot;
        int   listed;
        k      = key_in & KEY_MASK;
        nk     = new_in & KEY_MASK;
        listed = 0;
        case (act)
            ACT_ADD: begin
                if (k == '0) begin
                    push_answer(ST_INVALID, '0);
                end else begin
                    free_slot = find_slot('0);
                    if (free_slot < 0) begin
                        push_answer(ST_FULL, k);
                    end else if (find_slot(k) >= 0) begin
                        push_answer(ST_DUP, k);
                    end else begin
                        table_keys[free_slot] = k;
                        push_answer(ST_ADDED, k);
                    end
                end
            end
            ACT_REMOVE: begin
                if (k == '0) begin
                    push_answer(ST_INVALID, '0);
                end else begin
                    old_slot = find_slot(k);
                    if (old_slot >= 0) begin
                        table_keys[old_slot] = '0;
                        push_answer(ST_REMOVED, k);
                    end else begin
                        push_answer(ST_ABSENT, k);
                    end
                end
            end
            ACT_EXCHANGE: begin
                if (k == '0 || nk == '0) begin
                    push_answer(ST_INVALID, '0);
                end else begin
                    old_slot = find_slot(k);
                    new_slot = find_slot(nk);
                    if (old_slot < 0) begin
                        push_answer(ST_ABSENT, k);
                    end else if (new_slot >= 0) begin
                        push_answer(ST_DUP, nk);
                    end else begin
                        table_keys[old_slot] = nk;
                        push_answer(ST_EXCHANGED, k);
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (table_keys[i] != '0) begin
                        push_answer(ST_LISTED, table_keys[i]);
                        listed++;
                    end
                end
                if (listed == 0) begin
                    push_answer(ST_EMPTY, '0);
                end
            end
        endcase
        answer_q[answer_q.size() - 1].last        = 1'b1;
        answer_q[answer_q.size() - 1].request_end = closes;
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                table_keys[i] = '0;
            end
            answer_q.delete();
        end else begin
            if (i_result_valid) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result, status", '0, 64'(i_status));
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch("status", 64'(want.status), 64'(i_status));
                    end
                    if (i_reported_key !== want.reported_key) begin
                        report_mismatch("reported_key", 64'(want.reported_key),
                                        64'(i_reported_key));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch("last", 64'(want.last), 64'(i_last));
                    end
                    if (i_request_end !== want.request_end) begin
                        report_mismatch("request_end", 64'(want.request_end),
                                        64'(i_request_end));
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_command(i_action, i_key, i_new_key, i_closes_request);
            end
        end
        o_pending <= answer_q.size();
    end

endmodule

// ===== sim/tb_bounded_key_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded key set table testbench
// Drives directed and random add, remove, exchange and list commands in
// bursts with random gaps, fills the table to capacity, then mixes traffic
// on the full table, and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_bounded_key_set_table_top;
    import bkst_pkg::*;

    localparam int POOL_SIZE = 100;

    logic    clk;
    logic    rst_n          = 1'b0;
    logic    start          = 1'b0;
    logic    busy;
    t_action action         = ACT_ADD;
    t_key    key            = '0;
    t_key    new_key        = '0;
    logic    closes_request = 1'b0;
    logic    result_valid;
    t_status status;
    t_key    reported_key;
    logic    last;
    logic    request_end;
    int      fail_count;
    int      pending;

    t_key    name_pool [POOL_SIZE];
    int      pool_used  = 0;
    int      burst_left = 0;

    bounded_key_set_table_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (action),
        .i_key            (key),
        .i_new_key        (new_key),
        .i_closes_request (closes_request),
        .o_result_valid   (result_valid),
        .o_status         (status),
        .o_reported_key   (reported_key),
        .o_last           (last),
        .o_request_end    (request_end)
    );

    bounded_key_set_table_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_action         (action),
        .i_key            (key),
        .i_new_key        (new_key),
        .i_closes_request (closes_request),
        .i_result_valid   (result_valid),
        .i_status         (status),
        .i_reported_key   (reported_key),
        .i_last           (last),
        .i_request_end    (request_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_key random_key();
        return t_key'({$urandom, $urandom}) & KEY_MASK;
    endfunction

    function automatic t_key fresh_name(input int count);
        t_key k;
        logic clash;
        do begin
            k     = random_key();
            clash = (k == '0);
            for (int i = 0; i < count; i++) begin
                if (name_pool[i] == k) begin
                    clash = 1'b1;
                end
            end
        end while (clash);
        return k;
    endfunction

    function automatic t_key known_name();
        return name_pool[$urandom_range(0, (pool_used > 0) ? pool_used - 1 : 0)];
    endfunction

    function automatic t_key any_name();
        return name_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_command(input t_action act, input t_key k, input t_key nk,
                                input logic closes);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80)
                                              : $urandom_range(0, 4);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        start          <= 1'b1;
        action         <= act;
        key            <= k;
        new_key        <= nk;
        closes_request <= closes;
        @(posedge clk);
        while (busy) @(posedge clk);
        burst_left--;
    endtask

    initial begin
        int   sel;
        t_key k;
        logic closes;

        for (int i = 0; i < POOL_SIZE; i++) begin
            name_pool[i] = fresh_name(i);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases on a fresh table.
        send_command(ACT_LIST, random_key(), random_key(), 1'b1);
        send_command(ACT_ADD, '0, random_key(), 1'b0);
        send_command(ACT_REMOVE, '0, KEY_MASK, 1'b1);
        send_command(ACT_EXCHANGE, '0, name_pool[0], 1'b1);
        send_command(ACT_EXCHANGE, name_pool[0], '0, 1'b0);
        send_command(ACT_ADD, KEY_MASK, KEY_MASK, 1'b0);
        send_command(ACT_ADD, t_key'(1), '0, 1'b1);
        send_command(ACT_ADD, KEY_MASK, random_key(), 1'b1);
        send_command(ACT_REMOVE, name_pool[1], random_key(), 1'b0);
        send_command(ACT_EXCHANGE, name_pool[1], name_pool[2], 1'b1);
        send_command(ACT_EXCHANGE, KEY_MASK, t_key'(1), 1'b0);
        send_command(ACT_EXCHANGE, KEY_MASK, KEY_MASK, 1'b1);
        send_command(ACT_EXCHANGE, KEY_MASK, name_pool[0], 1'b1);
        send_command(ACT_LIST, KEY_MASK, KEY_MASK, 1'b0);
        send_command(ACT_REMOVE, t_key'(1), KEY_MASK, 1'b1);
        send_command(ACT_REMOVE, t_key'(1), '0, 1'b0);
        send_command(ACT_LIST, '0, '0, 1'b1);
        send_command(ACT_ADD, KEY_MASK, random_key(), 1'b1);
        pool_used = 1;

        // Fill the table past capacity, with the odd repeated name.
        for (int n = 0; n < 80; n++) begin
            closes = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                k = known_name();
            end else begin
                k = name_pool[pool_used];
                if (pool_used < POOL_SIZE - 1) begin
                    pool_used++;
                end
            end
            send_command(ACT_ADD, k, random_key(), closes);
        end
        send_command(ACT_LIST, random_key(), random_key(), 1'b1);

        // Mixed traffic on a crowded table.
        for (int n = 0; n < 110; n++) begin
            sel    = $urandom_range(0, 99);
            closes = 1'($urandom_range(0, 1));
            if (sel < 28) begin
                send_command(ACT_ADD, any_name(), random_key(), closes);
            end else if (sel < 58) begin
                k = ($urandom_range(0, 9) < 7) ? known_name() : any_name();
                send_command(ACT_REMOVE, k, random_key(), closes);
            end else if (sel < 90) begin
                k = ($urandom_range(0, 9) < 8) ? known_name() : any_name();
                send_command(ACT_EXCHANGE, k, any_name(), closes);
            end else if (sel < 94) begin
                send_command(ACT_LIST, random_key(), random_key(), closes);
            end else if (sel < 97) begin
                send_command(t_action'($urandom_range(0, 2)),
                             ($urandom_range(0, 1) == 0) ? '0 : any_name(),
                             ($urandom_range(0, 1) == 0) ? '0 : random_key(), closes);
            end else begin
                send_command(t_action'($urandom_range(0, 3)), random_key(),
                             random_key(), closes);
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bkst_pkg.sv
sv/bkst_ram.sv
sv/bounded_key_set_table_top.sv
sim/bounded_key_set_table_checker.sv
sim/tb_bounded_key_set_table_top.sv
